// ===== rtl/hdt_pkg.sv =====
// hdt_pkg: shared types, constants and helpers of the header dynamic table
// used by hdt_front, hdt_back and header_dynamic_table; no dependencies
package hdt_pkg;

    localparam int STORE_BYTES    = 4096;
    localparam int MAX_ENTRIES    = 128;
    localparam int ENTRY_OVERHEAD = 32;

    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int SLOT_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = SLOT_W + 1;
    localparam int LEN_W  = 12;
    localparam int PEND_W = LEN_W + 1;
    localparam int CAP_W  = 13;
    localparam int IDX_W  = 7;
    localparam int BYTE_W = 8;
    // wide enough for every sum and product of the size checks
    localparam int WIDE_W = 24;

    typedef logic [WIDE_W-1:0] wide_t;

    typedef enum logic [1:0] {
        CMD_PUSH_BEGIN = 2'd0,
        CMD_PUSH_BYTE  = 2'd1,
        CMD_PEEK       = 2'd2,
        CMD_POP        = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TOO_BIG  = 2'd1,
        ST_NO_ENTRY = 2'd2,
        ST_NO_PUSH  = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [LEN_W-1:0]  name_length;
        logic [LEN_W-1:0]  value_length;
        logic [BYTE_W-1:0] data_byte;
        logic [IDX_W-1:0]  entry_index;
        logic [LEN_W-1:0]  byte_offset;
        logic [LEN_W-1:0]  name_room;
        logic [LEN_W-1:0]  value_room;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  name_len;
        logic [LEN_W-1:0]  value_len;
    } meta_t;

    // single conditional subtract, value known below twice the modulus
    function automatic wide_t wrap(input wide_t x, input wide_t m);
        return (x >= m) ? x - m : x;
    endfunction

endpackage

// ===== rtl/hdt_front.sv =====
// hdt_front: accepts input transfers and queues them for the back end
// depends on hdt_pkg
module hdt_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  hdt_pkg::item_t             in_item,
    output hdt_pkg::q_head_t           head,
    input  logic                       head_pop
);

    hdt_pkg::item_t q_mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push, pop;

    assign in_ready   = (fill_reg != 2'd2);
    assign push       = in_valid && in_ready;
    assign pop        = head_pop && (fill_reg != 2'd0);
    assign head.valid = (fill_reg != 2'd0);
    assign head.item  = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== rtl/hdt_back.sv =====
// hdt_back: executes queued commands against the entry table and byte store
// depends on hdt_pkg
module hdt_back
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [hdt_pkg::CAP_W-1:0]        capacity,
    input  hdt_pkg::q_head_t                 head,
    output logic                             head_pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       status,
    output logic [hdt_pkg::LEN_W-1:0]        entry_name_length,
    output logic [hdt_pkg::LEN_W-1:0]        entry_value_length,
    output logic                             name_fits,
    output logic                             value_fits,
    output logic [hdt_pkg::BYTE_W-1:0]       peek_byte
);

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_EVAL      = 7'b0000010,
        S_EVICT     = 7'b0000100,
        S_POP       = 7'b0001000,
        S_PEEK_META = 7'b0010000,
        S_PEEK_BYTE = 7'b0100000,
        S_DONE      = 7'b1000000
    } state_t;

    typedef struct packed {
        hdt_pkg::status_t            status;
        logic [hdt_pkg::LEN_W-1:0]   name_len;
        logic [hdt_pkg::LEN_W-1:0]   value_len;
        logic                        name_fits;
        logic                        value_fits;
        logic [hdt_pkg::BYTE_W-1:0]  pbyte;
    } res_t;

    localparam hdt_pkg::wide_t MAX_W   = hdt_pkg::WIDE_W'(hdt_pkg::MAX_ENTRIES);
    localparam hdt_pkg::wide_t STORE_W = hdt_pkg::WIDE_W'(hdt_pkg::STORE_BYTES);
    localparam hdt_pkg::wide_t OVH_W   = hdt_pkg::WIDE_W'(hdt_pkg::ENTRY_OVERHEAD);
    localparam hdt_pkg::wide_t ONE_W   = hdt_pkg::WIDE_W'(1);

    // memories
    hdt_pkg::meta_t              meta_mem [hdt_pkg::MAX_ENTRIES];
    logic [hdt_pkg::BYTE_W-1:0]  byte_mem [hdt_pkg::STORE_BYTES];

    hdt_pkg::meta_t              meta_rdata, meta_wdata;
    logic [hdt_pkg::SLOT_W-1:0]  meta_raddr, meta_waddr;
    logic                        meta_we;
    logic [hdt_pkg::BYTE_W-1:0]  byte_rdata, byte_wdata;
    logic [hdt_pkg::ADDR_W-1:0]  byte_raddr, byte_waddr;
    logic                        byte_we;

    state_t                      state_reg, state_next;
    hdt_pkg::item_t              item_reg, item_next;
    res_t                        res_reg, res_next;
    res_t                        out_reg, out_next;
    logic                        out_valid_reg, out_valid_next;
    hdt_pkg::meta_t              pmeta_reg, pmeta_next;
    logic [hdt_pkg::SLOT_W-1:0]  oldest_reg, oldest_next;
    logic [hdt_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [hdt_pkg::CAP_W-1:0]   used_reg, used_next;
    logic [hdt_pkg::ADDR_W-1:0]  wp_reg, wp_next;
    logic [hdt_pkg::ADDR_W-1:0]  fill_pos_reg, fill_pos_next;
    logic [hdt_pkg::PEND_W-1:0]  pending_reg, pending_next;

    hdt_pkg::wide_t used_w, cnt_w, data_w, cost_w, ovh_w, held_w, drop_w, sum_w;
    logic           need_evict;

    always_comb
    begin
        used_w = hdt_pkg::WIDE_W'(used_reg);
        cnt_w  = hdt_pkg::WIDE_W'(count_reg);
        data_w = hdt_pkg::WIDE_W'(item_reg.name_length)
               + hdt_pkg::WIDE_W'(item_reg.value_length);
        cost_w = data_w + OVH_W;
        ovh_w  = cnt_w * OVH_W;
        held_w = (used_w >= ovh_w) ? used_w - ovh_w : '0;
        drop_w = OVH_W + hdt_pkg::WIDE_W'(meta_rdata.name_len)
               + hdt_pkg::WIDE_W'(meta_rdata.value_len);
        need_evict = (used_w + cost_w >= hdt_pkg::WIDE_W'(capacity))
                  || (cnt_w >= MAX_W)
                  || (held_w + data_w > STORE_W);
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        pmeta_next     = pmeta_reg;
        oldest_next    = oldest_reg;
        count_next     = count_reg;
        used_next      = used_reg;
        wp_next        = wp_reg;
        fill_pos_next  = fill_pos_reg;
        pending_next   = pending_reg;
        head_pop       = 1'b0;
        meta_we        = 1'b0;
        meta_waddr     = '0;
        meta_wdata     = '0;
        meta_raddr     = oldest_reg;
        byte_we        = 1'b0;
        byte_waddr     = fill_pos_reg;
        byte_wdata     = item_reg.data_byte;
        byte_raddr     = '0;
        sum_w          = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    head_pop  = 1'b1;
                    item_next = head.item;
                    res_next  = '0;
                    case (head.item.cmd)
                        hdt_pkg::CMD_PUSH_BEGIN:
                        begin
                            pending_next = '0;
                            state_next   = S_EVAL;
                        end
                        hdt_pkg::CMD_PUSH_BYTE:
                        begin
                            if (pending_reg == '0 || count_reg == '0)
                            begin
                                res_next.status = hdt_pkg::ST_NO_PUSH;
                            end
                            else
                            begin
                                byte_we       = 1'b1;
                                byte_wdata    = head.item.data_byte;
                                sum_w         = hdt_pkg::wrap(
                                    hdt_pkg::WIDE_W'(fill_pos_reg) + ONE_W, STORE_W);
                                fill_pos_next = sum_w[hdt_pkg::ADDR_W-1:0];
                                pending_next  = pending_reg - 1'b1;
                            end
                            state_next = S_DONE;
                        end
                        hdt_pkg::CMD_PEEK:
                        begin
                            if (hdt_pkg::WIDE_W'(head.item.entry_index) >= cnt_w)
                            begin
                                res_next.status = hdt_pkg::ST_NO_ENTRY;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                // newest is oldest + count - 1
                                sum_w = hdt_pkg::wrap(hdt_pkg::WIDE_W'(oldest_reg) + cnt_w
                                    - ONE_W - hdt_pkg::WIDE_W'(head.item.entry_index),
                                    MAX_W);
                                meta_raddr = sum_w[hdt_pkg::SLOT_W-1:0];
                                state_next = S_PEEK_META;
                            end
                        end
                        default:
                        begin
                            state_next = (count_reg == '0) ? S_DONE : S_POP;
                        end
                    endcase
                end
            end
            S_EVAL:
            begin
                if (need_evict)
                begin
                    if (count_reg == '0)
                    begin
                        res_next.status = hdt_pkg::ST_TOO_BIG;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_EVICT;
                    end
                end
                else
                begin
                    sum_w      = hdt_pkg::wrap(hdt_pkg::WIDE_W'(oldest_reg) + cnt_w, MAX_W);
                    meta_we    = 1'b1;
                    meta_waddr = sum_w[hdt_pkg::SLOT_W-1:0];
                    meta_wdata.start     = wp_reg;
                    meta_wdata.name_len  = item_reg.name_length;
                    meta_wdata.value_len = item_reg.value_length;
                    count_next    = count_reg + 1'b1;
                    used_next     = hdt_pkg::CAP_W'(used_w + cost_w);
                    fill_pos_next = wp_reg;
                    sum_w         = hdt_pkg::wrap(hdt_pkg::WIDE_W'(wp_reg) + data_w, STORE_W);
                    wp_next       = sum_w[hdt_pkg::ADDR_W-1:0];
                    pending_next  = hdt_pkg::PEND_W'(data_w);
                    state_next    = S_DONE;
                end
            end
            S_EVICT, S_POP:
            begin
                used_next   = (used_w >= drop_w) ? hdt_pkg::CAP_W'(used_w - drop_w) : '0;
                sum_w       = hdt_pkg::wrap(hdt_pkg::WIDE_W'(oldest_reg) + ONE_W, MAX_W);
                oldest_next = sum_w[hdt_pkg::SLOT_W-1:0];
                count_next  = count_reg - 1'b1;
                if (count_reg == hdt_pkg::CNT_W'(1))
                begin
                    pending_next = '0;
                end
                state_next = (state_reg == S_EVICT) ? S_EVAL : S_DONE;
            end
            S_PEEK_META:
            begin
                pmeta_next = meta_rdata;
                sum_w      = hdt_pkg::wrap(hdt_pkg::WIDE_W'(meta_rdata.start)
                           + hdt_pkg::WIDE_W'(item_reg.byte_offset), STORE_W);
                byte_raddr = sum_w[hdt_pkg::ADDR_W-1:0];
                state_next = S_PEEK_BYTE;
            end
            S_PEEK_BYTE:
            begin
                res_next.status     = hdt_pkg::ST_OK;
                res_next.name_len   = pmeta_reg.name_len;
                res_next.value_len  = pmeta_reg.value_len;
                res_next.name_fits  = (pmeta_reg.name_len <= item_reg.name_room);
                res_next.value_fits = (pmeta_reg.value_len <= item_reg.value_room);
                res_next.pbyte      = ({1'b0, item_reg.byte_offset}
                    < {1'b0, pmeta_reg.name_len} + {1'b0, pmeta_reg.value_len})
                    ? byte_rdata : '0;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        meta_rdata <= meta_mem[meta_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (byte_we)
        begin
            byte_mem[byte_waddr] <= byte_wdata;
        end
        byte_rdata <= byte_mem[byte_raddr];
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
        pmeta_reg    <= pmeta_next;
        fill_pos_reg <= fill_pos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            oldest_reg    <= '0;
            count_reg     <= '0;
            used_reg      <= '0;
            wp_reg        <= '0;
            pending_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            oldest_reg    <= oldest_next;
            count_reg     <= count_next;
            used_reg      <= used_next;
            wp_reg        <= wp_next;
            pending_reg   <= pending_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign status             = out_reg.status;
    assign entry_name_length  = out_reg.name_len;
    assign entry_value_length = out_reg.value_len;
    assign name_fits          = out_reg.name_fits;
    assign value_fits         = out_reg.value_fits;
    assign peek_byte          = out_reg.pbyte;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hdt_pkg::WIDE_W'(count_reg) <= MAX_W)
        else $error("entry count above table size");

    a_pending_open: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != '0 |-> count_reg != '0)
        else $error("bytes owed with no entry");

    a_empty_used: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> used_reg == '0)
        else $error("empty table still charged");

    a_evict_loop: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EVICT |=> state_reg == S_EVAL)
        else $error("eviction did not return to size check");

endmodule

// ===== rtl/header_dynamic_table.sv =====
// header_dynamic_table: top level with configuration port, front queue and back end
// depends on hdt_pkg, hdt_front, hdt_back
//
// size-bounded fifo table of name/value byte entries; every input transfer gives
// exactly one result transfer, in order. a push begin evicts oldest entries until
// the new one fits (status too big if it never does), push bytes then fill name
// and value, pop drops the oldest, peek reads one byte of an entry (index 0 is
// newest) with its lengths and room checks. each item runs through the back-end
// sequencer with registered table and byte-store reads: a push begin repeats its
// size check after each eviction, and a peek reads the entry's sizes, then its byte.
// a two-entry input queue lets new transfers be taken while the back end works
// and while a result waits in the output register. capacity (register 0, byte
// address 0) is read and written over the apb port and applies at the next
// push begin size check; it never evicts by itself. no clearing pass after reset.
module header_dynamic_table
(
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [1:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    // input items
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       cmd,
    input  logic [hdt_pkg::LEN_W-1:0]        name_length,
    input  logic [hdt_pkg::LEN_W-1:0]        value_length,
    input  logic [hdt_pkg::BYTE_W-1:0]       data_byte,
    input  logic [hdt_pkg::IDX_W-1:0]        entry_index,
    input  logic [hdt_pkg::LEN_W-1:0]        byte_offset,
    input  logic [hdt_pkg::LEN_W-1:0]        name_room,
    input  logic [hdt_pkg::LEN_W-1:0]        value_room,
    // results
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       status,
    output logic [hdt_pkg::LEN_W-1:0]        entry_name_length,
    output logic [hdt_pkg::LEN_W-1:0]        entry_value_length,
    output logic                             name_fits,
    output logic                             value_fits,
    output logic [hdt_pkg::BYTE_W-1:0]       peek_byte
);

    // capacity register, reset to the full table
    logic [hdt_pkg::CAP_W-1:0] capacity_reg, capacity_next;
    logic                      cfg_wr;

    hdt_pkg::item_t   in_item;
    hdt_pkg::q_head_t head;
    logic             head_pop;

    // only one register, at byte address zero
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == 2'b00);
    assign prdata = {{(32-hdt_pkg::CAP_W){1'b0}}, capacity_reg};

    always_comb
    begin
        capacity_next = cfg_wr ? pwdata[hdt_pkg::CAP_W-1:0] : capacity_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= hdt_pkg::CAP_W'(4096);
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    // gather the payload ports into one item for the queue
    always_comb
    begin
        in_item.cmd          = hdt_pkg::cmd_t'(cmd);
        in_item.name_length  = name_length;
        in_item.value_length = value_length;
        in_item.data_byte    = data_byte;
        in_item.entry_index  = entry_index;
        in_item.byte_offset  = byte_offset;
        in_item.name_room    = name_room;
        in_item.value_room   = value_room;
    end

    // front: takes input transfers into a short queue
    hdt_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .head     (head),
        .head_pop (head_pop)
    );

    // back: sequencer over the entry table and byte store, owns the result register
    hdt_back u_back
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .capacity           (capacity_reg),
        .head               (head),
        .head_pop           (head_pop),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .status             (status),
        .entry_name_length  (entry_name_length),
        .entry_value_length (entry_value_length),
        .name_fits          (name_fits),
        .value_fits         (value_fits),
        .peek_byte          (peek_byte)
    );

endmodule
